@@ rtl/core/rce_pkg.sv @@
package rce_pkg;

    // Table geometry
    localparam int ENTRIES_PER_SECTION = 64;
    localparam int SECTIONS            = 4;
    localparam int SEC_W               = 2;
    localparam int IDX_W               = $clog2(ENTRIES_PER_SECTION);
    localparam int LIM_W               = IDX_W + 1;
    localparam int ADDR_W              = SEC_W + IDX_W;
    localparam int TBL_DEPTH           = SECTIONS * ENTRIES_PER_SECTION;

    // Field widths
    localparam int WORD_W      = 16;
    localparam int CNT_W       = 7;
    localparam int RND_W       = CNT_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ROUND_STEP  = 7;   // counts round up to a multiple of eight

    // Item modes
    localparam logic [2:0] MODE_SET     = 3'd0;
    localparam logic [2:0] MODE_CLEAR   = 3'd1;
    localparam logic [2:0] MODE_MERGE   = 3'd2;
    localparam logic [2:0] MODE_RECALC  = 3'd3;
    localparam logic [2:0] MODE_WRITE   = 3'd4;

    // Sections
    localparam logic [SEC_W-1:0] SEC_PREPARE = 2'd0;
    localparam logic [SEC_W-1:0] SEC_MAIN    = 2'd1;
    localparam logic [SEC_W-1:0] SEC_STATIC  = 2'd2;
    localparam logic [SEC_W-1:0] SEC_DYNAMIC = 2'd3;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREPARE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC    = 3'd4;

    typedef struct packed {
        logic [2:0]        mode;
        logic [3:0]        status_bit;
        logic [WORD_W-1:0] on_mask;
        logic [WORD_W-1:0] keep_mask;
        logic [SEC_W-1:0]  section;
        logic [5:0]        entry_index;
        logic [WORD_W-1:0] need_word;
        logic [WORD_W-1:0] yield_word;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] status_now;
        logic [WORD_W-1:0] main_output;
        logic              main_valid;
        logic [WORD_W-1:0] sensitives_word;
        logic              write_ignored;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] need;
        logic [WORD_W-1:0] yield;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_tbl_req;

    // Round up to a multiple of eight, saturate at the section size
    function automatic logic [LIM_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [RND_W-1:0] rnd;
        rnd = ({1'b0, cnt} + RND_W'(ROUND_STEP)) & ~RND_W'(ROUND_STEP);
        if (32'(rnd) > ENTRIES_PER_SECTION) begin
            return LIM_W'(ENTRIES_PER_SECTION);
        end
        return LIM_W'(rnd);
    endfunction

endpackage

@@ rtl/core/rce_ram.sv @@
module rce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rce_table.sv @@
module rce_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rce_pkg::t_tbl_req        i_req,
    input  logic [rce_pkg::WORD_W-1:0] i_against,
    output logic [rce_pkg::WORD_W-1:0] o_hit
);
    import rce_pkg::*;

    logic [2*WORD_W-1:0]  rd_data;
    logic [TBL_DEPTH-1:0] r_valid;
    logic                 r_ent_vld;
    logic [WORD_W-1:0]    need;
    logic [WORD_W-1:0]    yield;

    rce_ram #(
        .WIDTH (2*WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata ({i_req.need, i_req.yield}),
        .i_re    (i_req.re),
        .i_raddr (i_req.raddr),
        .o_rdata (rd_data)
    );

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ent_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_ent_vld <= r_valid[i_req.raddr];
            end
        end
    end

    assign need  = r_ent_vld ? rd_data[2*WORD_W-1:WORD_W] : '0;
    assign yield = r_ent_vld ? rd_data[WORD_W-1:0] : '0;
    assign o_hit = ((need & ~i_against) == '0) ? yield : '0;

endmodule

@@ rtl/core/relay_circuit_rule_evaluator.sv @@
// Channel   | Signals                                  | Transfer rule
// ----------+------------------------------------------+----------------------------------
// item in   | start, busy, i_item                      | start high and busy low at edge
// result    | o_done, o_result                         | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_idx, i_cfg_data          | write at any edge with i_cfg_we
//
// Set, clear, merge, write, unused modes: result strobes the next cycle, busy stays low.
// Recalculate: busy from the next cycle; each section with effective count n runs a setup step,
// n table reads in the run state and a drain step for the last read, or setup alone when n is 0.
// A partial pass walks only the dynamic section, a full pass all four; result in the next cycle.
// Reset: synchronous, active low; per-entry valid bits make the table read as zero, no sweep.
// The result side cannot stall.
module relay_circuit_rule_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rce_pkg::t_item                i_item,
    input  logic                          i_cfg_we,
    input  logic [rce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_done,
    output rce_pkg::t_result              o_result
);
    import rce_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // config registers
    logic [WORD_W-1:0] r_const_mask;
    logic [CNT_W-1:0]  r_cnt_prepare;
    logic [CNT_W-1:0]  r_cnt_main;
    logic [CNT_W-1:0]  r_cnt_static;
    logic [CNT_W-1:0]  r_cnt_dynamic;

    // architectural state
    logic [WORD_W-1:0] r_status;
    logic              r_pending;
    logic [WORD_W-1:0] r_widened;
    logic [WORD_W-1:0] r_static_sum;
    logic [WORD_W-1:0] r_sens;

    // sequencer
    logic [1:0]        r_state;
    logic [SEC_W-1:0]  r_sec;
    logic [LIM_W-1:0]  r_idx;
    logic              r_full;
    logic              r_rd_vld;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_main;

    // result
    logic              r_done;
    t_result           r_res;

    logic              accept;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  wr_cnt;
    logic [LIM_W-1:0]  cur_lim;
    logic [LIM_W-1:0]  wr_lim;
    logic              idx_ok;
    logic              wr_ok;
    logic [WORD_W-1:0] status_upd;
    logic [WORD_W-1:0] against;
    logic [WORD_W-1:0] hit;
    logic [WORD_W-1:0] acc_next;
    logic              last_rd;
    logic              sec_fin;
    logic [WORD_W-1:0] fin_val;
    t_tbl_req          tbl_req;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        case (r_sec)
            SEC_PREPARE: cur_cnt = r_cnt_prepare;
            SEC_MAIN:    cur_cnt = r_cnt_main;
            SEC_STATIC:  cur_cnt = r_cnt_static;
            default:     cur_cnt = r_cnt_dynamic;
        endcase
    end

    always_comb begin
        case (i_item.section)
            SEC_PREPARE: wr_cnt = r_cnt_prepare;
            SEC_MAIN:    wr_cnt = r_cnt_main;
            SEC_STATIC:  wr_cnt = r_cnt_static;
            default:     wr_cnt = r_cnt_dynamic;
        endcase
    end

    assign cur_lim = eff_count(cur_cnt);
    assign wr_lim  = eff_count(wr_cnt);
    assign idx_ok  = (32'(i_item.entry_index) < 32'(wr_lim));
    assign wr_ok   = accept && (i_item.mode == MODE_WRITE) && idx_ok;

    always_comb begin
        case (i_item.mode)
            MODE_SET:   status_upd = r_status | (WORD_W'(1) << i_item.status_bit);
            MODE_CLEAR: status_upd = r_status & ~(WORD_W'(1) << i_item.status_bit);
            MODE_MERGE: status_upd = i_item.on_mask | (r_status & i_item.keep_mask);
            default:    status_upd = r_status;
        endcase
    end

    // prepare entries test the raw status, every later section the widened one
    assign against  = (r_sec == SEC_PREPARE) ? r_status : r_widened;
    assign acc_next = r_rd_vld ? (r_acc | hit) : r_acc;
    assign last_rd  = (r_idx == LIM_W'(cur_lim - 1'b1));

    // a section closes either empty at setup or after its last read drains
    assign sec_fin = ((r_state == ST_SETUP) && (cur_lim == '0)) || (r_state == ST_DRAIN);
    assign fin_val = (r_state == ST_DRAIN) ? acc_next : '0;

    always_comb begin
        tbl_req.we    = wr_ok;
        tbl_req.waddr = {i_item.section, IDX_W'(i_item.entry_index)};
        tbl_req.need  = i_item.need_word;
        tbl_req.yield = i_item.yield_word;
        tbl_req.re    = (r_state == ST_RUN);
        tbl_req.raddr = {r_sec, r_idx[IDX_W-1:0]};
    end

    rce_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_against (against),
        .o_hit     (hit)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_mask  <= '0;
            r_cnt_prepare <= '0;
            r_cnt_main    <= '0;
            r_cnt_static  <= '0;
            r_cnt_dynamic <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONST_MASK: r_const_mask  <= i_cfg_data;
                CFG_PREPARE:    r_cnt_prepare <= i_cfg_data[CNT_W-1:0];
                CFG_MAIN:       r_cnt_main    <= i_cfg_data[CNT_W-1:0];
                CFG_STATIC:     r_cnt_static  <= i_cfg_data[CNT_W-1:0];
                CFG_DYNAMIC:    r_cnt_dynamic <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // main sequencer and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_status     <= '0;
            r_pending    <= 1'b1;
            r_widened    <= '0;
            r_static_sum <= '0;
            r_sens       <= '0;
            r_sec        <= SEC_PREPARE;
            r_idx        <= '0;
            r_full       <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            // strobe: quick modes the cycle after the transaction, recalc after its last section
            r_done   <= (accept && (i_item.mode != MODE_RECALC)) ||
                        (sec_fin && (r_sec == SEC_DYNAMIC));
            r_rd_vld <= (r_state == ST_RUN);

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_item.mode == MODE_RECALC) begin
                            // no status change since last full pass: dynamic only
                            r_full  <= r_pending;
                            r_sec   <= r_pending ? SEC_PREPARE : SEC_DYNAMIC;
                            r_state <= ST_SETUP;
                        end else begin
                            r_status <= status_upd;
                            if (status_upd != r_status) begin
                                r_pending <= 1'b1;
                            end
                            r_res.status_now       <= status_upd;
                            r_res.main_output      <= '0;
                            r_res.main_valid       <= 1'b0;
                            r_res.sensitives_word  <= r_sens;
                            r_res.write_ignored    <= (i_item.mode == MODE_WRITE) && !idx_ok;
                        end
                    end
                end
                ST_SETUP: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    if (cur_lim != '0) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_idx <= r_idx + 1'b1;
                    r_acc <= acc_next;
                    if (last_rd) begin
                        r_state <= ST_DRAIN;
                    end
                end
                default: ;
            endcase

            if (sec_fin) begin
                case (r_sec)
                    SEC_PREPARE: r_widened    <= r_status | fin_val;
                    SEC_MAIN:    r_main       <= fin_val;
                    SEC_STATIC:  r_static_sum <= r_const_mask | fin_val;
                    default:     r_sens       <= r_static_sum | fin_val;
                endcase
                if (r_sec == SEC_DYNAMIC) begin
                    r_pending              <= 1'b0;
                    r_state                <= ST_IDLE;
                    r_res.status_now       <= r_status;
                    r_res.main_output      <= r_full ? r_main : '0;
                    r_res.main_valid       <= r_full;
                    r_res.sensitives_word  <= r_static_sum | fin_val;
                    r_res.write_ignored    <= 1'b0;
                end else begin
                    r_sec   <= r_sec + 1'b1;
                    r_state <= ST_SETUP;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ rtl/core/rce_checker.sv @@
module rce_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  rce_pkg::t_item                 i_item,
    input  logic                           o_done,
    input  rce_pkg::t_result               o_result
);
    import rce_pkg::*;

    // a recalculation always occupies the block before answering
    a_recalc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.mode == MODE_RECALC) |=> busy && !o_done)
        else $error("recalc transaction did not raise busy");

    // every other mode answers in the next cycle
    a_quick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.mode != MODE_RECALC) |=> o_done && !busy)
        else $error("single-cycle transaction missing its result");

    a_main_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.main_valid |-> (o_result.main_output == '0))
        else $error("main output nonzero without full pass");

    a_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.main_valid |-> !o_result.write_ignored)
        else $error("full pass result flagged as ignored write");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("activity right after reset");

endmodule

bind relay_circuit_rule_evaluator rce_checker u_rce_checker (.*);

@@ sim/relay_circuit_rule_evaluator_tb.sv @@
module relay_circuit_rule_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rce_pkg::*;

    // Modes the block decodes as no-ops
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

    // Past this many mismatches only the count goes up
    localparam int MAX_REPORTS = 40;
    // Drain wait, covering the worst transaction: four sections of 64 entries each, then the strobe
    localparam int DRAIN_CYCLES = 300;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_item                 i_item     = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_done;
    t_result               o_result;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    relay_circuit_rule_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // ------------------------------------------------------------------
    // Mirror of the block state, kept in step with accepted transactions
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] const_mask     = '0;
    logic [CNT_W-1:0]  sec_count [SECTIONS];
    logic [WORD_W-1:0] status_mirror  = '0;
    logic              full_due       = 1'b1;   // status moved since the last full pass
    logic [WORD_W-1:0] widened_mirror = '0;     // status plus fired prepare yields
    logic [WORD_W-1:0] static_or      = '0;     // constant mask plus fired static yields
    logic [WORD_W-1:0] sens_mirror    = '0;
    logic [WORD_W-1:0] need_mem  [TBL_DEPTH];
    logic [WORD_W-1:0] yield_mem [TBL_DEPTH];

    t_item   pending_q [$];     // items not yet handed to the driver
    t_result expected_q [$];    // results owed by the block, oldest first
    t_result want;

    int items_queued = 0;
    int results_seen = 0;
    int errors       = 0;
    int burst_left   = 0;
    int gap_left     = 0;

    // Entries in use: count rounded up to a multiple of eight, capped at the section size
    function automatic int active_entries(logic [SEC_W-1:0] sec);
        int n;
        n = (int'(sec_count[sec]) + 7) / 8 * 8;
        return (n > ENTRIES_PER_SECTION) ? ENTRIES_PER_SECTION : n;
    endfunction

    // OR of the yields of every entry in use whose need bits are all present
    function automatic logic [WORD_W-1:0] fired_or(logic [SEC_W-1:0] sec,
                                                   logic [WORD_W-1:0] against);
        logic [WORD_W-1:0] acc;
        int slot;
        acc = '0;
        for (int i = 0; i < active_entries(sec); i++) begin
            slot = int'(sec) * ENTRIES_PER_SECTION + i;
            if ((need_mem[slot] & ~against) == '0) begin
                acc |= yield_mem[slot];
            end
        end
        return acc;
    endfunction

    // Applies one accepted item to the mirror and returns the result it owes
    function automatic t_result evaluate_item(t_item it);
        t_result r;
        logic [WORD_W-1:0] prev;
        int slot;
        r = '0;
        prev = status_mirror;
        case (it.mode)
            MODE_SET: begin
                status_mirror = status_mirror | (16'h1 << it.status_bit);
            end
            MODE_CLEAR: begin
                status_mirror = status_mirror & ~(16'h1 << it.status_bit);
            end
            MODE_MERGE: begin
                status_mirror = it.on_mask | (status_mirror & it.keep_mask);
            end
            MODE_RECALC: begin
                // Full pass only when the status moved; otherwise just the dynamic
                // section against the retained widened status
                if (full_due) begin
                    widened_mirror = status_mirror | fired_or(SEC_PREPARE, status_mirror);
                    r.main_output  = fired_or(SEC_MAIN, widened_mirror);
                    r.main_valid   = 1'b1;
                    static_or      = const_mask | fired_or(SEC_STATIC, widened_mirror);
                end
                sens_mirror = static_or | fired_or(SEC_DYNAMIC, widened_mirror);
                full_due = 1'b0;
            end
            MODE_WRITE: begin
                if (int'(it.entry_index) < active_entries(it.section)) begin
                    slot = int'(it.section) * ENTRIES_PER_SECTION + int'(it.entry_index);
                    need_mem[slot]  = it.need_word;
                    yield_mem[slot] = it.yield_word;
                end else begin
                    r.write_ignored = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (status_mirror != prev) begin
            full_due = 1'b1;
        end
        r.status_now      = status_mirror;
        r.sensitives_word = sens_mirror;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; start holds while busy
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_q.size() > 0) begin
                start  <= 1'b1;
                i_item <= pending_q.pop_front();
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks the result strobe first, then records the transaction
    // accepted at this edge, so a result never meets its own expectation early
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %p with no transaction outstanding",
                                              o_result));
                end else begin
                    want = expected_q.pop_front();
                    results_seen++;
                    if (o_result.status_now !== want.status_now) begin
                        report_mismatch($sformatf("status_now %h, expected %h",
                                                  o_result.status_now, want.status_now));
                    end
                    if (o_result.main_output !== want.main_output) begin
                        report_mismatch($sformatf("main_output %h, expected %h",
                                                  o_result.main_output, want.main_output));
                    end
                    if (o_result.main_valid !== want.main_valid) begin
                        report_mismatch($sformatf("main_valid %b, expected %b",
                                                  o_result.main_valid, want.main_valid));
                    end
                    if (o_result.sensitives_word !== want.sensitives_word) begin
                        report_mismatch($sformatf("sensitives_word %h, expected %h",
                                                  o_result.sensitives_word,
                                                  want.sensitives_word));
                    end
                    if (o_result.write_ignored !== want.write_ignored) begin
                        report_mismatch($sformatf("write_ignored %b, expected %b",
                                                  o_result.write_ignored,
                                                  want.write_ignored));
                    end
                end
            end else if (o_done !== 1'b0) begin
                report_mismatch("o_done unknown");
            end
            if (start && !busy) begin
                expected_q = {expected_q, evaluate_item(i_item)};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Every field random; callers overwrite the ones that matter
    function automatic t_item any_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_item)-1:0];
    endfunction

    function automatic t_item op_bit(logic [2:0] mode, logic [3:0] bit_no);
        t_item it;
        it = any_item();
        it.mode = mode;
        it.status_bit = bit_no;
        return it;
    endfunction

    function automatic t_item op_merge(logic [WORD_W-1:0] on_m, logic [WORD_W-1:0] keep_m);
        t_item it;
        it = any_item();
        it.mode = MODE_MERGE;
        it.on_mask = on_m;
        it.keep_mask = keep_m;
        return it;
    endfunction

    function automatic t_item op_write(logic [SEC_W-1:0] sec, logic [5:0] idx,
                                       logic [WORD_W-1:0] need, logic [WORD_W-1:0] yld);
        t_item it;
        it = any_item();
        it.mode = MODE_WRITE;
        it.section = sec;
        it.entry_index = idx;
        it.need_word = need;
        it.yield_word = yld;
        return it;
    endfunction

    function automatic t_item op_plain(logic [2:0] mode);
        t_item it;
        it = any_item();
        it.mode = mode;
        return it;
    endfunction

    // Random mix: recalcs and writes dominate; need words are mostly sparse so
    // that entries actually fire against a status word
    function automatic t_item random_item();
        t_item it;
        int pick;
        int lim;
        it = any_item();
        case ($urandom_range(0, 4))
            0: it.need_word = '0;
            1: it.need_word = 16'h1 << $urandom_range(0, 15);
            2: it.need_word = (16'h1 << $urandom_range(0, 15)) |
                              (16'h1 << $urandom_range(0, 15));
            3: it.need_word = 16'($urandom & $urandom & $urandom);
            default: begin
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            it.mode = MODE_SET;
        end else if (pick < 24) begin
            it.mode = MODE_CLEAR;
        end else if (pick < 38) begin
            it.mode = MODE_MERGE;
            if ($urandom_range(0, 1) == 0) begin
                it.on_mask = it.on_mask & 16'($urandom);
            end
        end else if (pick < 64) begin
            it.mode = MODE_RECALC;
        end else if (pick < 96) begin
            it.mode = MODE_WRITE;
            lim = active_entries(it.section);
            // mostly land inside the section, sometimes anywhere
            if (lim > 0 && $urandom_range(0, 3) != 0) begin
                it.entry_index = 6'($urandom_range(0, lim - 1));
            end
        end else begin
            it.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end
        return it;
    endfunction

    task automatic queue_item(t_item it);
        pending_q = {pending_q, it};
        items_queued++;
    endtask

    // Returns once every queued transaction has produced its result
    task automatic wait_idle();
        while (results_seen != items_queued) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; the mirror follows at once since the block is idle
    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CONST_MASK: const_mask = val;
            CFG_PREPARE:    sec_count[SEC_PREPARE] = val[CNT_W-1:0];
            CFG_MAIN:       sec_count[SEC_MAIN]    = val[CNT_W-1:0];
            CFG_STATIC:     sec_count[SEC_STATIC]  = val[CNT_W-1:0];
            CFG_DYNAMIC:    sec_count[SEC_DYNAMIC] = val[CNT_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [WORD_W-1:0] cmask, logic [CNT_W-1:0] n_prep,
                             logic [CNT_W-1:0] n_main, logic [CNT_W-1:0] n_stat,
                             logic [CNT_W-1:0] n_dyn);
        program_reg(CFG_CONST_MASK, cmask);
        program_reg(CFG_PREPARE, CFG_DATA_W'(n_prep));
        program_reg(CFG_MAIN,    CFG_DATA_W'(n_main));
        program_reg(CFG_STATIC,  CFG_DATA_W'(n_stat));
        program_reg(CFG_DYNAMIC, CFG_DATA_W'(n_dyn));
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            queue_item(random_item());
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks, then random phases over several
    // configurations, each started only once the block has gone idle
    // ------------------------------------------------------------------
    initial begin
        foreach (need_mem[i]) begin
            need_mem[i]  = '0;
            yield_mem[i] = '0;
        end
        foreach (sec_count[i]) begin
            sec_count[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: every count zero, so all writes are dropped
        queue_item(op_plain(MODE_RECALC));              // full pass owed from reset
        queue_item(op_plain(MODE_RECALC));              // nothing moved: partial pass
        queue_item(op_write(SEC_PREPARE, 6'd0, 16'h0000, 16'hFFFF));
        queue_item(op_plain(MODE_UNUSED_FIRST));
        queue_item(op_plain(MODE_UNUSED_LAST));
        queue_item(op_bit(MODE_SET, 4'd15));
        queue_item(op_bit(MODE_SET, 4'd0));
        queue_item(op_bit(MODE_SET, 4'd0));             // no change
        queue_item(op_bit(MODE_CLEAR, 4'd15));
        queue_item(op_bit(MODE_CLEAR, 4'd15));          // no change
        queue_item(op_merge(16'h0000, 16'hFFFF));       // keeps everything
        queue_item(op_merge(16'hFFFF, 16'h0000));
        queue_item(op_plain(MODE_RECALC));
        wait_idle();

        // Rounding: 1 -> 8 entries, 63 -> 64, 7 -> 8; main at the full size
        configure(16'h1248, 7'd1, 7'd64, 7'd63, 7'd7);
        queue_item(op_write(SEC_PREPARE, 6'd7, 16'h0001, 16'h0100));   // last rounded slot
        queue_item(op_write(SEC_PREPARE, 6'd8, 16'h0001, 16'h0200));   // one past: dropped
        queue_item(op_write(SEC_MAIN, 6'd63, 16'h0101, 16'hFFFF));     // needs a widened bit
        queue_item(op_write(SEC_STATIC, 6'd0, 16'h0000, 16'h0002));    // always fires
        queue_item(op_write(SEC_DYNAMIC, 6'd0, 16'h0100, 16'h8000));
        queue_item(op_merge(16'h0001, 16'h0000));
        queue_item(op_plain(MODE_RECALC));
        queue_item(op_write(SEC_DYNAMIC, 6'd7, 16'hFFFF, 16'hFFFF));   // never fires here
        queue_item(op_write(SEC_STATIC, 6'd1, 16'h0000, 16'h4000));    // hidden until full pass
        queue_item(op_plain(MODE_RECALC));              // partial: static sum retained
        queue_item(op_write(SEC_DYNAMIC, 6'd63, 16'h0000, 16'h0001));  // beyond 8: dropped
        queue_item(op_bit(MODE_CLEAR, 4'd0));
        queue_item(op_plain(MODE_RECALC));
        wait_idle();

        configure(16'($urandom), 7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
                  7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)));
        random_phase(250);

        configure(16'hFFFF, 7'd64, 7'd64, 7'd64, 7'd64);
        random_phase(250);

        // Oversized counts saturate; an empty main section next to them
        configure(16'h0000, 7'd127, 7'd0, 7'd127, 7'd100);
        random_phase(250);

        configure(16'($urandom), 7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
                  7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
        random_phase(250);

        // Let any stray strobe show up before judging
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        end
        if (errors == 0) begin
            $display("** relay_circuit_rule_evaluator: PASSED **");
        end else begin
            $display("** relay_circuit_rule_evaluator: FAILED **");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #16_000_000;
        $display("** relay_circuit_rule_evaluator: FAILED **");
        $finish;
    end

endmodule
